// ===== hw/rtl/bcm_pkg.sv =====
// Shared types, codes and constants of the battery charge monitor.
package bcm_pkg;

  // Configuration register map, one word per register
  localparam int CfgAddrW = 4;

  typedef enum logic [1:0] {
    RegTickMs      = 2'd0,
    RegTimeoutMin  = 2'd1,
    RegTimeoutSec  = 2'd2,
    RegSleepOnUsb  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpTick     = 1'b0,
    OpActivity = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StUndet    = 2'd0,
    StCharging = 2'd1,
    StComplete = 2'd2,
    StAbsent   = 2'd3
  } charger_status_e;

  typedef enum logic [1:0] {
    PullNone = 2'd0,
    PullUp   = 2'd1,
    PullDown = 2'd2
  } pull_e;

  // Converter range that maps to 0..100 percent
  localparam int AdcLow  = 518;
  localparam int AdcHigh = 682;
  localparam int PctFull = 100;
  localparam int PctSpan = AdcHigh - AdcLow;
  localparam int PctW    = 7;
  localparam int AdcW    = 10;

  localparam int AvgSumW  = 13;
  localparam int MsPerMin = 60000;
  localparam int MsPerSec = 1000;
  localparam int LimitW   = 24;  // 255 min + 63 s in ms fits
  localparam int IdleW    = LimitW + 1;

  typedef logic [PctSpan-1:0][PctW-1:0] pct_lut_t;

  function automatic pct_lut_t build_pct_lut();
    pct_lut_t lut;
    for (int i = 0; i < PctSpan; i++) begin
      lut[i] = PctW'((i * PctFull) / PctSpan);
    end
    return lut;
  endfunction

  localparam pct_lut_t PctLut = build_pct_lut();

  typedef struct packed {
    logic            op;
    logic            stat_level;
    logic [AdcW-1:0] adc_sample;
    logic            usb_present;
  } bcm_in_t;

  typedef struct packed {
    logic [1:0]        pull_select;
    logic [1:0]        charger_status;
    logic signed [7:0] battery_percent;
    logic              sleep_request;
  } bcm_out_t;

endpackage

// ===== hw/rtl/battery_charge_monitor.sv =====
// Battery charge monitor: one input beat in per clock unless the result register is stalled.
// Each beat is a management tick or a user activity event. Every accepted beat yields exactly
// one result beat, held in the single result register from the cycle after acceptance; the
// block takes a new beat every clock as long as that register is empty or being drained in the
// same cycle, so the sustained rate is one item per cycle. Ticks step a four-phase probe of the
// charger status pin, feed the charge average unless the status reads absent, and advance the
// idle timer unless on USB power with sleep-on-USB off; activity events clear the timer only.
module battery_charge_monitor
  import bcm_pkg::*;
#(
  parameter int AVERAGE_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcm_in_t             in_data_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcm_out_t            out_data_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CntW     = $clog2(AVERAGE_COUNT + 1);
  // sum / AVERAGE_COUNT as a multiply by a rounded-up reciprocal; exact for any 13-bit sum
  localparam int DivShift = AvgSumW + 6;
  localparam int DivMulW  = DivShift + 1;
  localparam longint DivMul =
    ((longint'(1) << DivShift) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
  localparam int ProdW    = AvgSumW + DivMulW;

  typedef enum logic [1:0] {
    PhPullUp, PhReadUp, PhPullDown, PhReadDown
  } probe_phase_e;

  function automatic logic [LimitW-1:0] timeout_ms(logic [7:0] mins, logic [5:0] secs);
    return LimitW'(mins) * LimitW'(MsPerMin) + LimitW'(secs) * LimitW'(MsPerSec);
  endfunction

  // Configuration
  logic [15:0]       tick_ms_q;
  logic [7:0]        tmo_min_q;
  logic [5:0]        tmo_sec_q;
  logic              sleep_on_usb_q;
  logic [LimitW-1:0] limit_q;

  // Block state
  probe_phase_e      phase_q, phase_d;
  logic [1:0]        probe_sum_q, probe_sum_d;
  charger_status_e   status_q, status_d;
  pull_e             bias_q, bias_d;
  logic [AvgSumW-1:0] avg_sum_q, avg_sum_d;
  logic [CntW-1:0]   avg_cnt_q, avg_cnt_d;
  logic [PctW-1:0]   avg_res_q, avg_res_d;
  logic [IdleW-1:0]  idle_q, idle_d;

  logic              out_valid_q;
  bcm_out_t          out_data_q, out_data_d;

  logic              in_acc, cfg_wr;
  cfg_reg_e          cfg_idx;
  logic [AdcW-1:0]   adc_diff;
  logic [PctW-1:0]   pct;
  logic [AvgSumW-1:0] acc_sum;
  logic [CntW-1:0]   acc_cnt;
  logic [ProdW-1:0]  div_prod;
  logic [IdleW:0]    idle_sum;
  logic              sleep;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      RegTickMs:     prdata = {16'd0, tick_ms_q};
      RegTimeoutMin: prdata = {24'd0, tmo_min_q};
      RegTimeoutSec: prdata = {26'd0, tmo_sec_q};
      RegSleepOnUsb: prdata = {31'd0, sleep_on_usb_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Percent from the converter reading: below range is 0, beyond the span clamps to full
  assign adc_diff = in_data_i.adc_sample - AdcW'(AdcLow);
  always_comb begin
    if (in_data_i.adc_sample < AdcW'(AdcLow)) begin
      pct = '0;
    end else if (adc_diff >= AdcW'(PctSpan)) begin
      pct = PctW'(PctFull);
    end else begin
      pct = PctLut[adc_diff[7:0]];
    end
  end

  assign acc_sum  = avg_sum_q + AvgSumW'(pct);
  assign acc_cnt  = avg_cnt_q + CntW'(1);
  assign div_prod = ProdW'(acc_sum) * ProdW'(DivMul);
  assign idle_sum = (IdleW+1)'(idle_q) + (IdleW+1)'(tick_ms_q);

  always_comb begin
    phase_d     = phase_q;
    probe_sum_d = probe_sum_q;
    status_d    = status_q;
    bias_d      = bias_q;
    avg_sum_d   = avg_sum_q;
    avg_cnt_d   = avg_cnt_q;
    avg_res_d   = avg_res_q;
    idle_d      = idle_q;
    sleep       = 1'b0;

    if (in_acc) begin
      if (op_e'(in_data_i.op) == OpActivity) begin
        idle_d = '0;
      end else begin
        unique case (phase_q)
          PhPullUp: begin
            probe_sum_d = '0;
            bias_d      = PullUp;
            phase_d     = PhReadUp;
          end
          PhReadUp: begin
            probe_sum_d = probe_sum_q + 2'(in_data_i.stat_level);
            phase_d     = PhPullDown;
          end
          PhPullDown: begin
            bias_d  = PullDown;
            phase_d = PhReadDown;
          end
          PhReadDown: begin
            probe_sum_d = probe_sum_q + 2'(in_data_i.stat_level);
            priority if (probe_sum_d == 2'd0) begin
              status_d = StCharging;
            end else if (probe_sum_d == 2'd2) begin
              status_d = StComplete;
            end else begin
              status_d = StAbsent;
            end
            phase_d = PhPullUp;
          end
          default: phase_d = PhPullUp;
        endcase

        // Hold the average while the charger reads absent
        if (status_d != StAbsent) begin
          if (acc_cnt >= CntW'(AVERAGE_COUNT)) begin
            avg_res_d = div_prod[DivShift +: PctW];
            avg_sum_d = '0;
            avg_cnt_d = '0;
          end else begin
            avg_sum_d = acc_sum;
            avg_cnt_d = acc_cnt;
          end
        end

        if (!in_data_i.usb_present || sleep_on_usb_q) begin
          if (idle_sum >= (IdleW+1)'(limit_q)) begin
            sleep  = 1'b1;
            idle_d = '0;
          end else begin
            idle_d = IdleW'(idle_sum);
          end
        end else begin
          idle_d = '0;
        end
      end
    end

    out_data_d.pull_select     = bias_d;
    out_data_d.charger_status  = status_d;
    out_data_d.battery_percent = (status_d == StAbsent) ? -8'sd1
                                                        : $signed({1'b0, avg_res_d});
    out_data_d.sleep_request   = sleep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q      <= 16'd100;
      tmo_min_q      <= 8'd5;
      tmo_sec_q      <= '0;
      sleep_on_usb_q <= 1'b0;
      limit_q        <= timeout_ms(8'd5, 6'd0);
      phase_q        <= PhPullUp;
      probe_sum_q    <= '0;
      status_q       <= StUndet;
      bias_q         <= PullNone;
      avg_sum_q      <= '0;
      avg_cnt_q      <= '0;
      avg_res_q      <= '0;
      idle_q         <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          RegTickMs:     tick_ms_q <= pwdata[15:0];
          RegTimeoutMin: begin
            tmo_min_q <= pwdata[7:0];
            limit_q   <= timeout_ms(pwdata[7:0], tmo_sec_q);
          end
          RegTimeoutSec: begin
            tmo_sec_q <= pwdata[5:0];
            limit_q   <= timeout_ms(tmo_min_q, pwdata[5:0]);
          end
          RegSleepOnUsb: sleep_on_usb_q <= pwdata[0];
          default: ;
        endcase
      end

      phase_q     <= phase_d;
      probe_sum_q <= probe_sum_d;
      status_q    <= status_d;
      bias_q      <= bias_d;
      avg_sum_q   <= avg_sum_d;
      avg_cnt_q   <= avg_cnt_d;
      avg_res_q   <= avg_res_d;
      idle_q      <= idle_d;

      // Load a new result beat, or drop the one just taken
      if (in_acc) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_data_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/bcm_checker.sv =====
// Port-level checks of the battery charge monitor, bound to its top level.
module bcm_checker
  import bcm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input bcm_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input bcm_out_t out_data_o
);

  // A held result beat stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Every accepted beat shows up as a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Activity events never request sleep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.op == OpActivity |=>
      out_data_o.sleep_request == 1'b0)
    else $error("sleep request on activity event");

  // Percent reads -1 exactly when the charger is absent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.charger_status == StAbsent) ==
                     (out_data_o.battery_percent == -8'sd1)))
    else $error("percent and absent status disagree");

  // Bias is never the unused code, and percent never exceeds full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pull_select != 2'd3 &&
                    out_data_o.battery_percent <= 8'sd100)
    else $error("result field out of range");

endmodule

bind battery_charge_monitor bcm_checker u_bcm_checker (.*);

// ===== test/tb_battery_charge_monitor.sv =====
// Self-checking testbench for the battery charge monitor: random and directed beats, APB setup.
module tb_battery_charge_monitor;
  import bcm_pkg::*;

  localparam int AvgCount = 8;

  typedef enum logic [1:0] {
    PhPullUp,
    PhReadUp,
    PhPullDown,
    PhReadDown
  } probe_phase_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  bcm_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  bcm_out_t            out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  battery_charge_monitor #(
    .AVERAGE_COUNT(AvgCount)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the configuration
  logic [15:0] tick_ms_q   = 16'd100;
  logic [7:0]  tmo_min_q   = 8'd5;
  logic [5:0]  tmo_sec_q   = 6'd0;
  logic        usb_sleep_q = 1'b0;

  // Shadow copy of the monitor state
  probe_phase_e    probe_phase = PhPullUp;
  logic [1:0]      probe_sum   = '0;
  charger_status_e status_q    = StUndet;
  pull_e           bias_q      = PullNone;
  logic [12:0]     avg_sum     = '0;
  logic [6:0]      avg_count   = '0;
  logic [6:0]      avg_pct     = '0;
  logic [31:0]     idle_ms     = '0;

  bcm_in_t  pending_beats[$];
  bcm_out_t expected_reports[$];
  bcm_out_t want_report;
  int       mismatch_count = 0;
  int       idle_pct       = 7;
  bit       tx_hold        = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] adc_to_pct(logic [AdcW-1:0] sample);
    int p;
    if (sample < AdcLow) return '0;
    p = ((int'(sample) - AdcLow) * PctFull) / (AdcHigh - AdcLow);
    return (p > PctFull) ? 7'(PctFull) : 7'(p);
  endfunction

  function automatic bcm_out_t advance_monitor(bcm_in_t beat);
    bcm_out_t    rep;
    logic [31:0] limit;
    rep = '0;
    if (beat.op == OpActivity) begin
      idle_ms = '0;
    end else begin
      case (probe_phase)
        PhPullUp: begin
          probe_sum   = '0;
          bias_q      = PullUp;
          probe_phase = PhReadUp;
        end
        PhReadUp: begin
          probe_sum   = probe_sum + 2'(beat.stat_level);
          probe_phase = PhPullDown;
        end
        PhPullDown: begin
          bias_q      = PullDown;
          probe_phase = PhReadDown;
        end
        default: begin
          probe_sum = probe_sum + 2'(beat.stat_level);
          if (probe_sum == 2'd0) status_q = StCharging;
          else if (probe_sum == 2'd2) status_q = StComplete;
          else status_q = StAbsent;
          probe_phase = PhPullUp;
        end
      endcase

      // absent ticks leave the average alone
      if (status_q != StAbsent) begin
        avg_sum   = avg_sum + 13'(adc_to_pct(beat.adc_sample));
        avg_count = avg_count + 7'd1;
        if (avg_count >= AvgCount) begin
          avg_pct   = 7'(avg_sum / AvgCount);
          avg_sum   = '0;
          avg_count = '0;
        end
      end

      if (!beat.usb_present || usb_sleep_q) begin
        idle_ms = idle_ms + 32'(tick_ms_q);
        limit   = 32'(tmo_min_q) * 32'(MsPerMin) + 32'(tmo_sec_q) * 32'(MsPerSec);
        if (idle_ms >= limit) begin
          rep.sleep_request = 1'b1;
          idle_ms           = '0;
        end
      end else begin
        idle_ms = '0;
      end
    end
    rep.pull_select     = bias_q;
    rep.charger_status  = status_q;
    rep.battery_percent = (status_q == StAbsent) ? -8'sd1 : $signed({1'b0, avg_pct});
    return rep;
  endfunction

  // Driver: predict on every accepted beat, then refill the slot
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_reports.push_back(advance_monitor(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && !tx_hold && $urandom_range(99) >= idle_pct) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data_o);
          mismatch_count++;
        end else begin
          want_report = expected_reports.pop_front();
          if (out_data_o.pull_select !== want_report.pull_select) begin
            $error("pull_select: expected %0d, got %0d",
                   want_report.pull_select, out_data_o.pull_select);
            mismatch_count++;
          end
          if (out_data_o.charger_status !== want_report.charger_status) begin
            $error("charger_status: expected %0d, got %0d",
                   want_report.charger_status, out_data_o.charger_status);
            mismatch_count++;
          end
          if (out_data_o.battery_percent !== want_report.battery_percent) begin
            $error("battery_percent: expected %0d, got %0d",
                   want_report.battery_percent, out_data_o.battery_percent);
            mismatch_count++;
          end
          if (out_data_o.sleep_request !== want_report.sleep_request) begin
            $error("sleep_request: expected %0d, got %0d",
                   want_report.sleep_request, out_data_o.sleep_request);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic bcm_in_t mk_beat(op_e op, logic stat, logic [AdcW-1:0] adc, logic usb);
    bcm_in_t b;
    b.op          = op;
    b.stat_level  = stat;
    b.adc_sample  = adc;
    b.usb_present = usb;
    return b;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegTickMs:     tick_ms_q   = value[15:0];
      RegTimeoutMin: tmo_min_q   = value[7:0];
      RegTimeoutSec: tmo_sec_q   = value[5:0];
      RegSleepOnUsb: usb_sleep_q = value[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Write all four registers, sometimes with junk above each register's width
  task automatic set_timing(logic [15:0] tick, logic [7:0] mins, logic [5:0] secs,
                            logic usb_sleep);
    logic [31:0] junk;
    junk = $urandom_range(1) ? $urandom : 32'd0;
    write_reg(RegTickMs, {junk[31:16], tick});
    write_reg(RegTimeoutMin, {junk[31:8], mins});
    write_reg(RegTimeoutSec, {junk[31:6], secs});
    write_reg(RegSleepOnUsb, {junk[31:1], usb_sleep});
  endtask

  task automatic queue_random(int count);
    bcm_in_t b;
    logic    hold_level;
    bit      level_random;
    hold_level   = 1'b0;
    level_random = 1'b0;
    for (int i = 0; i < count; i++) begin
      // over each run of twelve beats the pin is held steady or left random; steady runs let the average get going
      if (i % 12 == 0) begin
        hold_level   = 1'($urandom_range(1));
        level_random = 1'($urandom_range(1));
      end
      b.op          = ($urandom_range(99) < 12) ? OpActivity : OpTick;
      b.stat_level  = level_random ? 1'($urandom_range(1)) : hold_level;
      b.adc_sample  = $urandom_range(1) ? AdcW'($urandom_range(700, 500)) : AdcW'($urandom);
      b.usb_present = ($urandom_range(99) < 30);
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: undetermined status, each probe outcome, converter extremes
    pending_beats.push_back(mk_beat(OpActivity, 1'b0, 10'd0,    1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd0,    1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd517,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd518,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd682,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd683,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd1023, 1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd600,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd1023, 1'b0));
    pending_beats.push_back(mk_beat(OpActivity, 1'b1, 10'd1023, 1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd640,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd640,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd640,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd640,  1'b0));
    pending_beats.push_back(mk_beat(OpActivity, 1'b0, 10'd0,    1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd700,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd700,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd700,  1'b1));
    pending_beats.push_back(mk_beat(OpTick,     1'b1, 10'd700,  1'b1));
    wait_drained();

    // Zero timeout: sleep on every running tick, none on USB power
    set_timing(16'd1, 8'd0, 6'd0, 1'b0);
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd550,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd550,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd550,  1'b1));
    pending_beats.push_back(mk_beat(OpActivity, 1'b0, 10'd550,  1'b0));
    pending_beats.push_back(mk_beat(OpTick,     1'b0, 10'd550,  1'b0));
    wait_drained();

    set_timing(16'd1000, 8'd0, 6'd3, 1'b0);
    queue_random(60);
    wait_drained();

    set_timing(16'd65535, 8'd255, 6'd59, 1'b1);
    queue_random(60);
    wait_drained();

    // Long stretch with no idling on either side
    idle_pct = 0;
    set_timing(16'd1, 8'd0, 6'd0, 1'b1);
    queue_random(60);
    wait_drained();
    idle_pct = 7;

    // Seconds above 59, with the sender held until every result is back
    set_timing(16'd500, 8'd0, 6'd63, 1'b0);
    queue_random(60);
    do @(negedge clk_i); while (pending_beats.size() > 35);
    tx_hold = 1'b1;
    do @(negedge clk_i); while (in_valid_i || expected_reports.size() != 0);
    tx_hold = 1'b0;
    wait_drained();

    set_timing(16'($urandom_range(5000, 100)), 8'd0, 6'($urandom_range(63)),
               1'($urandom_range(1)));
    queue_random(60);
    wait_drained();

    set_timing(16'($urandom_range(65535, 1)), 8'($urandom_range(2)), 6'($urandom_range(59)),
               1'($urandom_range(1)));
    queue_random(60);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_battery_charge_monitor: clean");
    end else begin
      $display("tb_battery_charge_monitor: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_battery_charge_monitor: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bcm_pkg.sv
hw/rtl/battery_charge_monitor.sv
hw/rtl/bcm_checker.sv
test/tb_battery_charge_monitor.sv
